// ===== hdl/tpfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpfs_pkg
// types and constants shared by the test-pattern frame sequencer
// ---------------------------------------------------------------------------
package tpfs_pkg;

  localparam int MAX_FRAMES  = 32;
  localparam int DWELL_BITS  = 24;
  localparam int FRAME_BITS  = $clog2(MAX_FRAMES);
  localparam int COUNT_BITS  = 6;
  localparam int OPCODE_BITS = 3;
  localparam int ACTION_BITS = 2;

  localparam logic [DWELL_BITS-1:0] DWELL_MAX   = {DWELL_BITS{1'b1}};
  localparam logic [DWELL_BITS-1:0] DWELL_RESET =
    (1000 > ((64'd1 << DWELL_BITS) - 64'd1)) ? DWELL_MAX : DWELL_BITS'(1000);

  localparam logic [COUNT_BITS-1:0] FRAME_COUNT_RESET = COUNT_BITS'(3);

  localparam logic [OPCODE_BITS-1:0] OP_TICK       = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_KEY_POWER  = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_KEY_NEXT   = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_KEY_PREV   = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_KEY_AUTO   = 3'd4;
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_DWELL = 3'd5;

  localparam logic [ACTION_BITS-1:0] ACT_NONE      = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_SHOW      = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_POWER_ON  = 2'd2;
  localparam logic [ACTION_BITS-1:0] ACT_POWER_OFF = 2'd3;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [4:0]             dwell_frame;
    logic [DWELL_BITS-1:0]  dwell_value;
  } item_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [4:0]             shown_frame;
    logic                   panel_on;
    logic                   auto_on;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/tpfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpfs_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/test_pattern_frame_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// test_pattern_frame_sequencer
// picks the test-pattern frame a panel shows from key events, ms ticks and
// per-frame dwell loads; dwell times live in a 32-entry ram
// ---------------------------------------------------------------------------
//  channel  | handshake                | beat
//  ---------+--------------------------+---------------------------------
//  item     | item_valid / item_stall  | item_t: opcode, dwell frame/value
//  result   | result_valid/result_stall| result_t: action, frame, flags
//  cfg      | cfg_valid / cfg_ready    | frame_count, 6 bits
//
//  one item per cycle unless the result stalls; an item is registered in the
//  execute stage, its result in the output register
//  first the dwell ram is read, then the state is updated into the output
//  register; ram entries never loaded read as 1000 through per-entry valid bits
//  reset clears all state at once, no clearing pass
//  a stalled result holds; one more item is still taken, then the input stalls
// ---------------------------------------------------------------------------
module test_pattern_frame_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire tpfs_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output tpfs_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [5:0]       cfg_data
);

  import tpfs_pkg::*;

  logic [COUNT_BITS-1:0] frame_count;
  logic                  display_enabled, display_enabled_next;
  logic                  auto_advance, auto_advance_next;
  logic [FRAME_BITS-1:0] current_frame, current_frame_next;
  logic [DWELL_BITS-1:0] dwell_counter, dwell_counter_next;
  logic [MAX_FRAMES-1:0] dwell_written;

  logic                  ex_valid;
  item_t                 ex_item;
  logic                  fwd_hit;
  logic [DWELL_BITS-1:0] fwd_data;
  logic                  rd_written;

  logic                  accept, move;
  logic [FRAME_BITS-1:0] rd_addr;
  logic [DWELL_BITS-1:0] ram_rdata;
  logic [DWELL_BITS-1:0] dwell;
  logic [DWELL_BITS-1:0] counter_inc;
  logic [FRAME_BITS-1:0] last_frame;
  logic [FRAME_BITS-1:0] frame_fwd, frame_back;
  logic                  is_load;
  logic [ACTION_BITS-1:0] action_next;

  assign cfg_ready = 1'b1;

  assign move       = ex_valid && (!result_valid || !result_stall);
  assign item_stall = ex_valid && !move;
  assign accept     = item_valid && !item_stall;
  assign is_load    = ex_item.opcode == OP_LOAD_DWELL;

  // effective frame count clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      last_frame = '0;
    end else if (frame_count > COUNT_BITS'(MAX_FRAMES)) begin
      last_frame = FRAME_BITS'(MAX_FRAMES - 1);
    end else begin
      last_frame = FRAME_BITS'(frame_count - COUNT_BITS'(1));
    end
  end

  assign frame_fwd  = (current_frame < last_frame) ? current_frame + FRAME_BITS'(1) : '0;
  assign frame_back = (current_frame != '0) ? current_frame - FRAME_BITS'(1) : last_frame;

  assign dwell       = fwd_hit ? fwd_data : (rd_written ? ram_rdata : DWELL_RESET);
  assign counter_inc = dwell_counter + DWELL_BITS'(1);

  always_comb begin
    display_enabled_next = display_enabled;
    auto_advance_next    = auto_advance;
    current_frame_next   = current_frame;
    dwell_counter_next   = dwell_counter;
    action_next          = ACT_NONE;
    case (ex_item.opcode)
      OP_TICK: begin
        if (auto_advance && display_enabled) begin
          if (counter_inc >= dwell) begin
            dwell_counter_next = '0;
            current_frame_next = frame_fwd;
            action_next        = ACT_SHOW;
          end else begin
            dwell_counter_next = counter_inc;
          end
        end
      end
      OP_KEY_POWER: begin
        if (!display_enabled) begin
          dwell_counter_next   = '0;
          display_enabled_next = 1'b1;
          action_next          = ACT_POWER_ON;
        end else begin
          display_enabled_next = 1'b0;
          current_frame_next   = '0;
          action_next          = ACT_POWER_OFF;
        end
        auto_advance_next = 1'b0;
      end
      OP_KEY_NEXT: begin
        if (!auto_advance && display_enabled) begin
          current_frame_next = frame_fwd;
          action_next        = ACT_SHOW;
        end
      end
      OP_KEY_PREV: begin
        if (!auto_advance && display_enabled) begin
          current_frame_next = frame_back;
          action_next        = ACT_SHOW;
        end
      end
      OP_KEY_AUTO: begin
        auto_advance_next = !auto_advance;
      end
      default: begin
      end
    endcase
  end

  // read the dwell of the frame that holds once the item ahead has retired
  assign rd_addr = move ? current_frame_next : current_frame;

  tpfs_ram #(
    .WIDTH (DWELL_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_dwell_ram (
    .clk   (clk),
    .we    (move && is_load),
    .waddr (ex_item.dwell_frame[FRAME_BITS-1:0]),
    .wdata (ex_item.dwell_value),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= FRAME_COUNT_RESET;
      display_enabled <= 1'b1;
      auto_advance    <= 1'b0;
      current_frame   <= '0;
      dwell_counter   <= '0;
      dwell_written   <= '0;
      ex_valid        <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_count <= cfg_data;
      end
      if (move) begin
        display_enabled <= display_enabled_next;
        auto_advance    <= auto_advance_next;
        current_frame   <= current_frame_next;
        dwell_counter   <= dwell_counter_next;
        if (is_load) begin
          dwell_written[ex_item.dwell_frame[FRAME_BITS-1:0]] <= 1'b1;
        end
      end
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (move) begin
        ex_valid <= 1'b0;
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload and read-side bypass of a load to the entry being read
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item    <= item;
      fwd_hit    <= move && is_load && (ex_item.dwell_frame[FRAME_BITS-1:0] == rd_addr);
      fwd_data   <= ex_item.dwell_value;
      rd_written <= dwell_written[rd_addr];
    end
    if (move) begin
      result.action      <= action_next;
      result.shown_frame <= 5'(current_frame_next);
      result.panel_on    <= display_enabled_next;
      result.auto_on     <= auto_advance_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tpfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpfs_checker
// port-level checks on the frame sequencer, bound to the top level
// ---------------------------------------------------------------------------
module tpfs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire tpfs_pkg::result_t result
);

  import tpfs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_off_frame0: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.panel_on |-> result.shown_frame == '0)
    else $error("panel off but frame not zero");

  a_power_on: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action == ACT_POWER_ON |-> result.panel_on && !result.auto_on)
    else $error("power-on beat with wrong flags");

  a_show_on: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action == ACT_SHOW |-> result.panel_on)
    else $error("show beat with panel off");

endmodule

bind test_pattern_frame_sequencer tpfs_checker u_tpfs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ===== dv/test_pattern_frame_sequencer_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// test_pattern_frame_sequencer_test
// self-checking bench for the frame sequencer: key, tick and dwell-load beats
// go in under random idle and stall, every result beat is checked against a
// frame tracker that follows panel, auto mode, frame, dwell counter and table
// ---------------------------------------------------------------------------
module test_pattern_frame_sequencer_test;
  import tpfs_pkg::*;

  localparam int LIMIT = 200000;

  class frame_tracker;
    logic [COUNT_BITS-1:0] frame_count;
    bit                    panel;
    bit                    autoadv;
    logic [4:0]            frame;
    logic [DWELL_BITS-1:0] dwell_count;
    logic [DWELL_BITS-1:0] dwell_ms [MAX_FRAMES];
    result_t               pending_views [$];
    int                    errors;
    int                    checked;
    int                    auto_steps;

    function new();
      frame_count = FRAME_COUNT_RESET;
      panel       = 1'b1;
      autoadv     = 1'b0;
      frame       = '0;
      dwell_count = '0;
      foreach (dwell_ms[i]) dwell_ms[i] = DWELL_RESET;
      errors      = 0;
      checked     = 0;
      auto_steps  = 0;
    endfunction

    // frame count as the block sees it: 0 acts as 1, big values clamp
    function int span();
      if (frame_count == 0) return 1;
      if (frame_count > MAX_FRAMES) return MAX_FRAMES;
      return int'(frame_count);
    endfunction

    function void step(bit fwd);
      if (fwd) frame = (int'(frame) < span() - 1) ? frame + 5'd1 : 5'd0;
      else frame = (frame > 0) ? frame - 5'd1 : 5'(span() - 1);
    endfunction

    function void note_item(item_t it);
      result_t r;
      r.action = ACT_NONE;
      case (it.opcode)
        OP_TICK: begin
          if (autoadv && panel) begin
            dwell_count = dwell_count + 1'b1;
            if (dwell_count >= dwell_ms[frame]) begin
              dwell_count = '0;
              step(1'b1);
              r.action = ACT_SHOW;
              auto_steps++;
            end
          end
        end
        OP_KEY_POWER: begin
          if (!panel) begin
            dwell_count = '0;
            panel       = 1'b1;
            r.action    = ACT_POWER_ON;
          end else begin
            panel    = 1'b0;
            frame    = '0;
            r.action = ACT_POWER_OFF;
          end
          autoadv = 1'b0;
        end
        OP_KEY_NEXT, OP_KEY_PREV: begin
          if (!autoadv && panel) begin
            step(it.opcode == OP_KEY_NEXT);
            r.action = ACT_SHOW;
          end
        end
        OP_KEY_AUTO: autoadv = !autoadv;
        OP_LOAD_DWELL: dwell_ms[it.dwell_frame] = it.dwell_value;
        default: ;
      endcase
      r.shown_frame = frame;
      r.panel_on    = panel;
      r.auto_on     = autoadv;
      pending_views.push_back(r);
    endfunction

    function void check_view(result_t got);
      result_t want;
      if (pending_views.size() == 0) begin
        $error("result beat %h with nothing outstanding", got);
        errors++;
        return;
      end
      want = pending_views.pop_front();
      checked++;
      if (got.action !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, got.action);
        errors++;
      end
      if (got.shown_frame !== want.shown_frame) begin
        $error("shown_frame: expected %0d, actual %0d", want.shown_frame, got.shown_frame);
        errors++;
      end
      if (got.panel_on !== want.panel_on) begin
        $error("panel_on: expected %0d, actual %0d", want.panel_on, got.panel_on);
        errors++;
      end
      if (got.auto_on !== want.auto_on) begin
        $error("auto_on: expected %0d, actual %0d", want.auto_on, got.auto_on);
        errors++;
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data     = '0;

  bit           calm        = 1'b0;
  int           items_sent  = 0;
  int           count_writes = 0;
  int unsigned  cycles      = 0;
  frame_tracker board       = new();

  test_pattern_frame_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_view(result);
  end

  function automatic item_t key_item(logic [2:0] op, logic [4:0] fr, logic [23:0] val);
    item_t it;
    it.opcode      = op;
    it.dwell_frame = fr;
    it.dwell_value = val;
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    board.note_item(it);
    items_sent++;
    gap = (!calm && $urandom_range(0, 99) < 28) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_frame_count(logic [5:0] v);
    item_valid <= 1'b0;
    while (board.pending_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.frame_count = v;
    count_writes++;
  endtask

  initial begin
    int         n;
    int         sel;
    int         phase;
    logic [5:0] cnt;
    logic [5:0] settings [7];
    item_t      it;

    settings = '{6'd1, 6'd2, 6'd32, 6'd0, 6'd63, 6'd33, 6'd7};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // manual stepping and wrap over the reset count of three
    write_frame_count(FRAME_COUNT_RESET);
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));
    // zero, largest and short dwell, then auto advance
    send_item(key_item(OP_LOAD_DWELL, 5'd0, 24'd0));
    send_item(key_item(OP_LOAD_DWELL, 5'd1, DWELL_MAX));
    send_item(key_item(OP_LOAD_DWELL, 5'd2, 24'd2));
    send_item(key_item(OP_KEY_AUTO, 5'd31, DWELL_MAX));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));
    send_item(key_item(OP_TICK, 5'd0, 24'd0));
    send_item(key_item(OP_TICK, 5'd0, 24'd0));
    send_item(key_item(OP_TICK, 5'd0, 24'd0));
    send_item(key_item(OP_TICK, 5'd0, 24'd0));
    send_item(key_item(3'd6, 5'd31, DWELL_MAX));
    send_item(key_item(3'd7, 5'd31, DWELL_MAX));
    // panel off: keys ignored, auto still toggles, ticks do nothing
    send_item(key_item(OP_KEY_POWER, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_AUTO, 5'd0, 24'd0));
    send_item(key_item(OP_TICK, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_POWER, 5'd0, 24'd0));
    send_item(key_item(OP_LOAD_DWELL, 5'd31, 24'd0));
    // full count, then a zero count with the frame left beyond it
    write_frame_count(6'd32);
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));
    write_frame_count(6'd0);
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_PREV, 5'd0, 24'd0));

    // dwell out of an entry never loaded
    write_frame_count(6'd32);
    if (!board.panel) send_item(key_item(OP_KEY_POWER, 5'd0, 24'd0));
    if (board.autoadv) send_item(key_item(OP_KEY_AUTO, 5'd0, 24'd0));
    while (board.frame != 5'd5) send_item(key_item(OP_KEY_NEXT, 5'd0, 24'd0));
    send_item(key_item(OP_KEY_AUTO, 5'd0, 24'd0));
    repeat (1001) send_item(key_item(OP_TICK, 5'($urandom), 24'($urandom)));

    phase = 0;
    while (items_sent < 1830) begin
      if (phase < 7) begin
        cnt = settings[phase];
      end else begin
        sel = $urandom_range(0, 9);
        cnt = (sel < 8) ? 6'($urandom_range(1, 6)) : 6'($urandom);
      end
      write_frame_count(cnt);
      calm = (phase == 4);
      n = $urandom_range(80, 200);
      repeat (n) begin
        it.dwell_frame = 5'($urandom);
        it.dwell_value = 24'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45) it.opcode = OP_TICK;
        else if (sel < 57) it.opcode = OP_KEY_NEXT;
        else if (sel < 69) it.opcode = OP_KEY_PREV;
        else if (sel < 76) it.opcode = OP_KEY_AUTO;
        else if (sel < 80) it.opcode = OP_KEY_POWER;
        else if (sel < 97) it.opcode = OP_LOAD_DWELL;
        else it.opcode = 3'($urandom_range(6, 7));
        if (it.opcode == OP_LOAD_DWELL) begin
          sel = $urandom_range(0, 9);
          if (sel < 6) it.dwell_value = 24'($urandom_range(0, 4));
          else if (sel == 8) it.dwell_value = DWELL_MAX;
          else if (sel == 9) it.dwell_value = 24'($urandom_range(5, 40));
        end
        send_item(it);
      end
      phase++;
    end
    calm = 1'b0;

    item_valid <= 1'b0;
    while (board.pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d beats over %0d frame-count settings, %0d results checked",
             items_sent, count_writes, board.checked);
    $display("auto mode advanced the frame %0d times", board.auto_steps);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
